// File: rtl/core/varint_field_decoder_unit_defines.svh
// assertion macros shared by the varint field decoder rtl
`ifndef VARINT_FIELD_DECODER_UNIT_DEFINES_SVH
`define VARINT_FIELD_DECODER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// plain property, checked on every clock edge outside reset
`define VFD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// implication: when ante holds, cons must hold in the same cycle
`define VFD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define VFD_ASSERT(label, prop, msg)
`define VFD_ASSERT_IMP(label, ante, cons, msg)
`endif

`endif

// File: rtl/core/vfd_pkg.sv
// shared types and constants of the varint field decoder
package vfd_pkg;

	localparam logic [7:0] PAYLOAD_MASK = 8'h7f;
	localparam logic [3:0] MAX_BYTES    = 4'd9;
	localparam int         LAST_SHIFT   = 56;
	localparam logic [3:0] MAX_WIDTH    = 4'd8;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TOO_BIG   = 2'd1;
	localparam logic [1:0] ST_TRUNCATED = 2'd2;

	localparam int VFD_QUEUE_DEPTH = 2;

	// one finished or cut value handed from front to back
	typedef struct packed {
		logic [63:0] acc;
		logic [3:0]  count;
		logic [3:0]  width;
		logic        sgn;
		logic        trunc;
	} job_t;

endpackage

// File: rtl/core/varint_field_decoder_unit.sv
// top level of the varint field decoder
// varint field decoder: rebuilds little-endian base-128 integers from a byte stream
//
// input channel s_*: one message byte per transfer, s_tlast marks the last byte
// of the buffer, s_tuser selects the signed (sign in bit 0) form. width request
// and sign flag are sampled on the first byte of each value only.
// output channel m_*: one transfer per decoded value with value, encoded length
// and status (ok, too big for the requested width, truncated at buffer end).
//
// throughput: one byte per cycle while the job queue has room, set by the single
// accumulator register in the front end; every byte only shifts into it.
// the result of a value is written into the queue at the transfer of its last byte
// and then passes through the output register before it shows on m_tvalid.
//
// reset clears the byte count, the job queue and the output valid; the first
// byte after reset starts a new value.
// when m_tready is low the output register holds its result; the queue between
// front and back takes further finished values, and s_tready drops only once
// the queue is full.
module varint_field_decoder_unit
	import vfd_pkg::*;
#(
	parameter int QUEUE_DEPTH = VFD_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] data_byte, [11:8] value_bytes, [15:12] zero
	input  logic        s_tlast,   // end_of_buffer
	input  logic        s_tuser,   // [0] signed_form
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [63:0] value, [67:64] encoded_length, [71:68] zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	// front to queue transfer
	logic push_valid;
	logic push_ready;
	job_t push_job;

	// queue to back transfer
	logic pop_valid;
	logic pop_ready;
	job_t pop_job;

	logic [63:0] value;
	logic [3:0]  encoded_length;

	// front: accumulate payload groups, classify end of value or cut
	vfd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.data_byte     (s_tdata[7:0]),
		.end_of_buffer (s_tlast),
		.value_bytes   (s_tdata[11:8]),
		.signed_form   (s_tuser),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_job      (push_job)
	);

	// decoupling queue so a stalled sink does not stop byte intake at once
	vfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	// back: width check, signed fold, truncation to the requested width
	vfd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.job_valid      (pop_valid),
		.job_ready      (pop_ready),
		.job            (pop_job),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.value          (value),
		.encoded_length (encoded_length),
		.status         (m_tuser)
	);

	// pack result fields, upper pad bits zero
	assign m_tdata = {4'd0, encoded_length, value};

endmodule

// File: rtl/core/vfd_front.sv
// front end: accepts bytes, gathers payload bits and emits finished values
`include "varint_field_decoder_unit_defines.svh"
module vfd_front
	import vfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       end_of_buffer,
	input  logic [3:0] value_bytes,
	input  logic       signed_form,
	output logic       push_valid,
	input  logic       push_ready,
	output job_t       push_job
);

	logic [63:0] acc_q;
	logic [3:0]  cnt_q;
	logic [3:0]  width_q;
	logic        sgn_q;

	logic        first;
	logic [3:0]  width_cur;
	logic        sgn_cur;
	logic [63:0] acc_base;
	logic [63:0] acc_new;
	logic [5:0]  shamt;
	logic [3:0]  cnt_next;
	logic        done;
	logic        emit;
	logic        fire;

	always_comb begin
		first     = (cnt_q == 4'd0);
		width_cur = first ? ((value_bytes > MAX_WIDTH) ? MAX_WIDTH : value_bytes) : width_q;
		sgn_cur   = first ? signed_form : sgn_q;
		acc_base  = first ? 64'd0 : acc_q;
		cnt_next  = cnt_q + 4'd1;
		// seven bits a byte: shift is 7 times the bytes already taken
		shamt     = ({3'b000, cnt_q[2:0]} << 3) - {3'b000, cnt_q[2:0]};
		if (cnt_next == MAX_BYTES) begin
			// ninth byte carries all eight bits at the top
			acc_new = acc_base | ({56'd0, data_byte} << LAST_SHIFT);
			done    = 1'b1;
		end else begin
			acc_new = acc_base | ({56'd0, data_byte & PAYLOAD_MASK} << shamt);
			done    = ~data_byte[7];
		end
		emit = done | end_of_buffer;
	end

	assign in_ready   = push_ready;
	assign fire       = in_valid & in_ready;
	assign push_valid = fire & emit;

	always_comb begin
		push_job.acc   = acc_new;
		push_job.count = cnt_next;
		push_job.width = width_cur;
		push_job.sgn   = sgn_cur;
		push_job.trunc = ~done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 4'd0;
		end else if (fire) begin
			cnt_q <= emit ? 4'd0 : cnt_next;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			acc_q   <= acc_new;
			width_q <= width_cur;
			sgn_q   <= sgn_cur;
		end
	end

	// a value in progress never holds more than eight bytes
	`VFD_ASSERT(a_cnt_range, cnt_q <= 4'd8, "byte count beyond eight")

endmodule

// File: rtl/core/vfd_queue.sv
// small job queue between front and back
module vfd_queue
	import vfd_pkg::*;
#(
	parameter int DEPTH = VFD_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_job,
	output logic pop_valid,
	input  logic pop_ready,
	output job_t pop_job
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	job_t            slots_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != CntW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = slots_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CntW'(1);
				2'b01:   count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// File: rtl/core/vfd_back.sv
// back end: range check, sign fold, width cut and output register
`include "varint_field_decoder_unit_defines.svh"
module vfd_back
	import vfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	output logic        job_ready,
	input  job_t        job,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] value,
	output logic [3:0]  encoded_length,
	output logic [1:0]  status
);

	logic        out_valid_q;
	logic [63:0] value_q;
	logic [3:0]  length_q;
	logic [1:0]  status_q;

	logic [63:0] keep_mask;
	logic        too_big;
	logic [63:0] shifted;
	logic [63:0] folded;
	logic [63:0] value_d;
	logic [1:0]  status_d;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			keep_mask[8*i +: 8] = {8{job.width > 4'(i)}};
		end
		// at least one significant bit always counts, so width zero is too big
		too_big = (job.width == 4'd0) | (|(job.acc & ~keep_mask));
		shifted = {1'b0, job.acc[63:1]};
		folded  = job.sgn ? (job.acc[0] ? (~shifted + 64'd1) : shifted) : job.acc;
		priority if (job.trunc) begin
			status_d = ST_TRUNCATED;
			value_d  = 64'd0;
		end else if (too_big) begin
			status_d = ST_TOO_BIG;
			value_d  = 64'd0;
		end else begin
			status_d = ST_OK;
			value_d  = folded & keep_mask;
		end
	end

	assign job_ready = ~out_valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (job_ready) begin
			out_valid_q <= job_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (job_ready & job_valid) begin
			value_q  <= value_d;
			length_q <= job.count;
			status_q <= status_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign value          = value_q;
	assign encoded_length = length_q;
	assign status         = status_q;

	`VFD_ASSERT_IMP(a_len_range, out_valid_q,
		(length_q != 4'd0) && (length_q <= MAX_BYTES), "encoded length out of range")
	`VFD_ASSERT_IMP(a_err_zero, out_valid_q && (status_q != ST_OK),
		value_q == 64'd0, "error result carries a nonzero value")
	`VFD_ASSERT_IMP(a_trunc_len, out_valid_q && (status_q == ST_TRUNCATED),
		length_q < MAX_BYTES, "truncated value reports nine bytes")

endmodule
